@@ rtl/core/lbm_pkg.sv @@
package lbm_pkg;

  localparam int CMD_W = 3;
  localparam int BOX_W = 11;
  localparam int SUM_W = 20;

  localparam logic [CMD_W-1:0] CMD_INIT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SWAP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REV   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SUM   = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [BOX_W-1:0] box_x;
    logic [BOX_W-1:0] box_y;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0] odd_sum;
    logic             error;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_INIT,
    ST_MV_A, ST_MV_B, ST_MV_C, ST_MV_D, ST_MV_E, ST_MV_F, ST_MV_G,
    ST_SW_1, ST_SW_2,
    ST_SU_0, ST_SU_1, ST_SU_W,
    ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LATCH, DP_FAIL, DP_REV, DP_INIT_WR,
    DP_RD_NX, DP_RD_NY, DP_RD_LA, DP_UNLINK, DP_RD_LB, DP_LINK_A, DP_LINK_Q,
    DP_SWAP_1, DP_SWAP_2,
    DP_SUM_START, DP_SUM_STEP0, DP_SUM_ACC,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             cmd_bad;
    logic             init_bad;
    logic             operand_bad;
    logic             is_left;
    logic             is_swap;
    logic             sweep_last;
    logic             walk_last;
    logic             out_free;
  } stat_t;

endpackage

@@ rtl/core/lbm_datapath.sv @@
module lbm_datapath
  import lbm_pkg::*;
#(
  parameter int MAX_BOXES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [BOX_W-1:0] cfg_data,
  input  in_t              in_data,
  input  ctl_t             ctl,
  output stat_t            stat,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data
);

  localparam int DEPTH = MAX_BOXES + 1;
  localparam int NW    = $clog2(DEPTH);

  logic [NW-1:0] next_mem [DEPTH];
  logic [NW-1:0] prev_mem [DEPTH];
  logic [NW-1:0] box_mem  [DEPTH];
  logic [NW-1:0] node_mem [DEPTH];

  logic [BOX_W-1:0] box_count, list_count;
  logic             reversed, initialised;
  logic [CMD_W-1:0] cmd_q;
  logic [BOX_W-1:0] x_q, y_q;
  logic [NW-1:0]    node_a, node_b, node_q, sweep;
  logic [BOX_W-1:0] walk_k;
  logic [SUM_W-1:0] sum_acc;
  logic             err_q;

  logic [NW-1:0] next_rd, prev_rd, box_rd, node_rd;
  logic [NW-1:0] link_raddr, node_raddr, box_raddr;
  logic          next_we, prev_we, box_we, node_we;
  logic [NW-1:0] next_waddr, prev_waddr, box_waddr, node_waddr;
  logic [NW-1:0] next_wdata, prev_wdata, box_wdata, node_wdata;

  logic [NW-1:0] walk_addr, x_node, y_node, q_sel;
  logic          sweep_last;

  assign walk_addr  = reversed ? prev_rd : next_rd;
  assign x_node     = NW'(x_q);
  assign y_node     = NW'(y_q);
  assign q_sel      = stat.is_left ? prev_rd : next_rd;
  assign sweep_last = (32'(sweep) == 32'(box_count));

  always_comb begin
    stat.command     = cmd_q;
    stat.cmd_bad     = (cmd_q > CMD_SUM) || (cmd_q != CMD_INIT && !initialised);
    stat.init_bad    = (box_count == '0) || (32'(box_count) > MAX_BOXES);
    stat.operand_bad = (x_q == '0) || (y_q == '0) || (x_q > list_count) ||
                       (y_q > list_count) || (x_q == y_q);
    stat.is_left     = (cmd_q == CMD_LEFT) ^ reversed;
    stat.is_swap     = (cmd_q == CMD_SWAP);
    stat.sweep_last  = sweep_last;
    stat.walk_last   = (walk_k == list_count);
    stat.out_free    = !out_valid || !out_stall;
  end

  // memory port steering per step
  always_comb begin
    link_raddr = '0;
    node_raddr = '0;
    box_raddr  = '0;
    next_we = 1'b0; next_waddr = '0; next_wdata = '0;
    prev_we = 1'b0; prev_waddr = '0; prev_wdata = '0;
    box_we  = 1'b0; box_waddr  = '0; box_wdata  = '0;
    node_we = 1'b0; node_waddr = '0; node_wdata = '0;
    case (ctl.op)
      DP_INIT_WR: begin
        next_we = 1'b1; next_waddr = sweep;
        next_wdata = sweep_last ? '0 : NW'(sweep + 1'b1);
        prev_we = 1'b1; prev_waddr = sweep;
        prev_wdata = (sweep == '0) ? NW'(box_count) : NW'(sweep - 1'b1);
        box_we  = 1'b1; box_waddr  = sweep; box_wdata  = sweep;
        node_we = 1'b1; node_waddr = sweep; node_wdata = sweep;
      end
      DP_RD_NX: node_raddr = x_node;
      DP_RD_NY: node_raddr = y_node;
      DP_RD_LA: link_raddr = node_a;
      DP_UNLINK: begin
        next_we = 1'b1; next_waddr = prev_rd; next_wdata = next_rd;
        prev_we = 1'b1; prev_waddr = next_rd; prev_wdata = prev_rd;
      end
      DP_RD_LB: link_raddr = node_b;
      DP_LINK_A: begin
        next_we = 1'b1; next_waddr = node_a;
        next_wdata = stat.is_left ? node_b : q_sel;
        prev_we = 1'b1; prev_waddr = node_a;
        prev_wdata = stat.is_left ? q_sel : node_b;
      end
      DP_LINK_Q: begin
        next_we = 1'b1; next_waddr = stat.is_left ? node_q : node_b; next_wdata = node_a;
        prev_we = 1'b1; prev_waddr = stat.is_left ? node_b : node_q; prev_wdata = node_a;
      end
      DP_SWAP_1: begin
        box_we  = 1'b1; box_waddr  = node_a; box_wdata  = y_node;
        node_we = 1'b1; node_waddr = x_node; node_wdata = node_b;
      end
      DP_SWAP_2: begin
        box_we  = 1'b1; box_waddr  = node_b; box_wdata  = x_node;
        node_we = 1'b1; node_waddr = y_node; node_wdata = node_a;
      end
      DP_SUM_START: link_raddr = '0;
      DP_SUM_STEP0, DP_SUM_ACC: begin
        link_raddr = walk_addr;
        box_raddr  = walk_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (box_we)  box_mem[box_waddr]   <= box_wdata;
    if (node_we) node_mem[node_waddr] <= node_wdata;
    next_rd <= next_mem[link_raddr];
    prev_rd <= prev_mem[link_raddr];
    box_rd  <= box_mem[box_raddr];
    node_rd <= node_mem[node_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      DP_LATCH: begin
        cmd_q   <= in_data.command;
        x_q     <= in_data.box_x;
        y_q     <= in_data.box_y;
        sweep   <= '0;
        sum_acc <= '0;
        err_q   <= 1'b0;
      end
      DP_FAIL:    err_q  <= 1'b1;
      DP_INIT_WR: sweep  <= NW'(sweep + 1'b1);
      DP_RD_NY:   node_a <= node_rd;
      DP_RD_LA:   node_b <= node_rd;
      DP_LINK_A:  node_q <= q_sel;
      DP_SUM_START: walk_k <= BOX_W'(1);
      DP_SUM_ACC: begin
        if (walk_k[0]) sum_acc <= sum_acc + SUM_W'(box_rd);
        walk_k <= walk_k + 1'b1;
      end
      DP_FINISH: out_data <= '{odd_sum: sum_acc, error: err_q};
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_count   <= BOX_W'(1);
      list_count  <= '0;
      reversed    <= 1'b0;
      initialised <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) box_count <= cfg_data;
      if (ctl.op == DP_REV) reversed <= !reversed;
      if (ctl.op == DP_INIT_WR && sweep_last) begin
        list_count  <= box_count;
        reversed    <= 1'b0;
        initialised <= 1'b1;
      end
      if (ctl.op == DP_FINISH) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/lbm_ctrl.sv @@
module lbm_ctrl
  import lbm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output ctl_t  ctl
);

  state_t state, state_next;
  logic   decode_fail;

  // rejected commands go straight to the result
  always_comb begin
    if (stat.command == CMD_INIT) decode_fail = stat.init_bad;
    else if (stat.cmd_bad) decode_fail = 1'b1;
    else if (stat.command == CMD_REV || stat.command == CMD_SUM) decode_fail = 1'b0;
    else decode_fail = stat.operand_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (decode_fail) state_next = ST_FIN;
        else if (stat.command == CMD_INIT) state_next = ST_INIT;
        else if (stat.command == CMD_REV) state_next = ST_FIN;
        else if (stat.command == CMD_SUM) state_next = ST_SU_0;
        else state_next = ST_MV_A;
      end
      ST_INIT: if (stat.sweep_last) state_next = ST_FIN;
      ST_MV_A: state_next = ST_MV_B;
      ST_MV_B: state_next = ST_MV_C;
      ST_MV_C: state_next = stat.is_swap ? ST_SW_1 : ST_MV_D;
      ST_MV_D: state_next = ST_MV_E;
      ST_MV_E: state_next = ST_MV_F;
      ST_MV_F: state_next = ST_MV_G;
      ST_MV_G: state_next = ST_FIN;
      ST_SW_1: state_next = ST_SW_2;
      ST_SW_2: state_next = ST_FIN;
      ST_SU_0: state_next = ST_SU_1;
      ST_SU_1: state_next = ST_SU_W;
      ST_SU_W: if (stat.walk_last) state_next = ST_FIN;
      ST_FIN:  if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op   = DP_NOP;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: if (in_valid) ctl.op = DP_LATCH;
      ST_DECODE: begin
        if (decode_fail) ctl.op = DP_FAIL;
        else if (stat.command == CMD_REV) ctl.op = DP_REV;
      end
      ST_INIT: ctl.op = DP_INIT_WR;
      ST_MV_A: ctl.op = DP_RD_NX;
      ST_MV_B: ctl.op = DP_RD_NY;
      ST_MV_C: ctl.op = DP_RD_LA;
      ST_MV_D: ctl.op = DP_UNLINK;
      ST_MV_E: ctl.op = DP_RD_LB;
      ST_MV_F: ctl.op = DP_LINK_A;
      ST_MV_G: ctl.op = DP_LINK_Q;
      ST_SW_1: ctl.op = DP_SWAP_1;
      ST_SW_2: ctl.op = DP_SWAP_2;
      ST_SU_0: ctl.op = DP_SUM_START;
      ST_SU_1: ctl.op = DP_SUM_STEP0;
      ST_SU_W: ctl.op = DP_SUM_ACC;
      ST_FIN:  if (stat.out_free) ctl.op = DP_FINISH;
      default: ctl.op = DP_NOP;
    endcase
  end

endmodule

@@ rtl/core/linked_list_box_mover.sv @@
// Accepted transaction to result valid: reverse and rejected go straight to the
// result; swap, move and sum walk memory steps; init sweeps one entry per cycle.
// Throughput: one transaction at a time; the link memories' single read port sets
// the move and walk step counts.
// Reset (rst, synchronous, active high): idle, no list built, box_count = 1,
// reversal flag clear; node memories hold undefined data until the first init.
module linked_list_box_mover
  import lbm_pkg::*;
#(
  parameter int MAX_BOXES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [BOX_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data
);

  // Controller walks each command through its memory steps; the datapath owns
  // the four node memories, operand checks and the output register.
  ctl_t  ctl;
  stat_t stat;

  lbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  lbm_datapath #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transaction is in flight");

  // a result load never overwrites a result still waiting downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == DP_FINISH) |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  // a flagged command reports a zero sum
  a_err_zero_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error) |-> (out_data.odd_sum == '0))
    else $error("error result carries a sum");

endmodule

@@ bench/lbm_checker.sv @@
`timescale 1ns / 100ps

module lbm_checker
  import lbm_pkg::*;
#(
  parameter int MAX_BOXES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [BOX_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_t              in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_t             out_data,
  output int               fail_count,
  output int               pending
);

  logic [BOX_W-1:0] count_reg;
  logic [BOX_W-1:0] built_count;
  logic [BOX_W-1:0] nxt  [0:MAX_BOXES];
  logic [BOX_W-1:0] prv  [0:MAX_BOXES];
  logic [BOX_W-1:0] box_of [0:MAX_BOXES];
  logic [BOX_W-1:0] node_of [0:MAX_BOXES];
  logic flipped, built;
  out_t result_q [$];

  function automatic logic [BOX_W-1:0] clip(logic [BOX_W-1:0] v);
    return (v <= MAX_BOXES) ? v : '0;
  endfunction

  task automatic detach(logic [BOX_W-1:0] a);
    logic [BOX_W-1:0] n, p;
    n = clip(nxt[a]);
    p = clip(prv[a]);
    nxt[p] = n;
    prv[n] = p;
  endtask

  task automatic apply_cmd(in_t t, output out_t r);
    logic [BOX_W-1:0] a, b, p, tmp;
    logic [SUM_W-1:0] acc;
    logic [CMD_W-1:0] op;
    r = '0;
    acc = '0;
    if (t.command == CMD_INIT) begin
      if (count_reg == 0 || count_reg > MAX_BOXES) begin
        r.error = 1'b1;
      end else begin
        for (int i = 0; i <= count_reg; i++) begin
          nxt[i] = (i == count_reg) ? '0 : BOX_W'(i + 1);
          prv[i] = (i == 0) ? count_reg : BOX_W'(i - 1);
          box_of[i] = BOX_W'(i);
          node_of[i] = BOX_W'(i);
        end
        built_count = count_reg;
        flipped = 1'b0;
        built = 1'b1;
      end
    end else if (t.command > CMD_SUM || !built) begin
      r.error = 1'b1;
    end else if (t.command == CMD_REV) begin
      flipped = !flipped;
    end else if (t.command == CMD_SUM) begin
      p = flipped ? clip(prv[0]) : clip(nxt[0]);
      for (int k = 1; k <= built_count; k++) begin
        if (k[0]) acc = acc + SUM_W'(box_of[p]);
        p = flipped ? clip(prv[p]) : clip(nxt[p]);
      end
      r.odd_sum = acc;
    end else if (t.box_x == 0 || t.box_y == 0 || t.box_x > built_count ||
                 t.box_y > built_count || t.box_x == t.box_y) begin
      r.error = 1'b1;
    end else begin
      a = clip(node_of[t.box_x]);
      b = clip(node_of[t.box_y]);
      op = t.command;
      if (flipped && op != CMD_SWAP) op = (op == CMD_LEFT) ? CMD_RIGHT : CMD_LEFT;
      if (op == CMD_LEFT) begin
        detach(a);
        p = clip(prv[b]);
        prv[a] = p; nxt[a] = b; nxt[p] = a; prv[b] = a;
      end else if (op == CMD_RIGHT) begin
        detach(a);
        p = clip(nxt[b]);
        nxt[a] = p; prv[a] = b; prv[p] = a; nxt[b] = a;
      end else begin
        tmp = box_of[a]; box_of[a] = box_of[b]; box_of[b] = tmp;
        node_of[t.box_x] = b;
        node_of[t.box_y] = a;
      end
    end
  endtask

  assign pending = result_q.size();

  always @(posedge clk) begin
    out_t want, got;
    if (rst) begin
      count_reg <= 1;
      flipped = 1'b0;
      built = 1'b0;
      built_count = '0;
      fail_count <= 0;
      result_q.delete();
    end else begin
      // result side first: a transaction cannot go in and out in one edge
      if (out_valid && !out_stall) begin
        got = out_data;
        if (result_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result sum=%0d err=%0b",
                                        got.odd_sum, got.error);
        end else begin
          want = result_q.pop_front();
          if (got.odd_sum !== want.odd_sum || got.error !== want.error) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected sum=%0d err=%0b, got sum=%0d err=%0b",
                       want.odd_sum, want.error, got.odd_sum, got.error);
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_cmd(in_data, want);
        result_q.push_back(want);
      end
      if (cfg_we) count_reg <= cfg_data;
    end
  end

endmodule

@@ bench/tb_linked_list_box_mover.sv @@
`timescale 1ns / 100ps

module tb_linked_list_box_mover;
  import lbm_pkg::*;

  logic clk, rst;
  logic cfg_we;
  logic [BOX_W-1:0] cfg_data;
  logic in_valid, in_stall;
  in_t in_data;
  logic out_valid, out_stall;
  out_t out_data;
  int fail_count, pending;

  // idle rates in percent for each side; hold_cycles > 0 forces a long stall
  int send_idle, recv_idle, hold_cycles;
  logic [BOX_W-1:0] span;  // current box count, used to aim operands

  linked_list_box_mover u_dut (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data
  );

  lbm_checker u_chk (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("FAIL");
    $finish;
  end

  // receiver: random stall, or a counted hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // offer one transaction and hold it until accepted; valid drops after the
  // accept, while the block is still busy anyway
  task automatic send(logic [CMD_W-1:0] c, logic [BOX_W-1:0] x, logic [BOX_W-1:0] y);
    in_t t;
    while ($urandom_range(99) < send_idle) @(posedge clk);
    t.command = c; t.box_x = x; t.box_y = y;
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain all results, then a margin for a result-free tail, before a config write
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic set_count(logic [BOX_W-1:0] n);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    span = n;
  endtask

  function automatic logic [BOX_W-1:0] pick_box();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 6) return BOX_W'($urandom);
    if (span == 0 || span > 1024) return BOX_W'($urandom_range(1024, 1));
    return BOX_W'($urandom_range(span, 1));
  endfunction

  // mostly moves and swaps, sums and reversals now and then, rare inits and bad codes
  task automatic random_burst(int n);
    int r;
    logic [CMD_W-1:0] c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2) c = CMD_INIT;
      else if (r < 28) c = CMD_LEFT;
      else if (r < 54) c = CMD_RIGHT;
      else if (r < 74) c = CMD_SWAP;
      else if (r < 84) c = CMD_REV;
      else if (r < 96) c = CMD_SUM;
      else c = CMD_W'($urandom_range(7, 6));
      send(c, pick_box(), pick_box());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    hold_cycles = 0;
    send_idle = 19;
    recv_idle = 78;
    span = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: commands before init, unknown codes, then the basic operations
    send(CMD_SUM, 1, 2);
    send(CMD_SWAP, 1, 2);
    send(3'd6, 0, 0);
    send(CMD_INIT, 0, 0);          // reset count of one box
    send(CMD_SUM, 0, 0);
    send(CMD_LEFT, 1, 1);
    set_count(0);
    send(CMD_INIT, 0, 0);          // rejected count
    set_count(11'd1025);
    send(CMD_INIT, 0, 0);          // count above the limit
    set_count(11'h7ff);
    send(CMD_INIT, 0, 0);
    set_count(6);
    send(CMD_INIT, 11'h7ff, 11'h7ff);
    send(CMD_LEFT, 1, 4);
    send(CMD_RIGHT, 6, 2);
    send(CMD_SWAP, 3, 5);
    send(CMD_SUM, 0, 0);
    send(CMD_REV, 0, 0);
    send(CMD_LEFT, 2, 6);          // roles trade while reversed
    send(CMD_RIGHT, 5, 1);
    send(CMD_SUM, 0, 0);
    send(CMD_SWAP, 0, 3);
    send(CMD_RIGHT, 7, 2);
    send(CMD_SWAP, 4, 4);
    send(3'd7, 11'h7ff, 11'h7ff);
    set_count(9);                  // latched only at the next init
    send(CMD_LEFT, 8, 1);
    send(CMD_SUM, 0, 0);
    send(CMD_INIT, 0, 0);

    // sender idles little, receiver a lot
    random_burst(400);
    set_count(1024);
    send(CMD_INIT, 0, 0);
    random_burst(60);
    set_count(3);
    send(CMD_INIT, 0, 0);
    // long receiver hold-off with the sender still offering
    hold_cycles = 300;
    random_burst(40);

    send_idle = 78;
    recv_idle = 19;
    set_count(2);
    send(CMD_INIT, 0, 0);
    random_burst(150);
    set_count(40);
    send(CMD_INIT, 0, 0);
    random_burst(250);
    // sender pauses until everything is back
    while (pending != 0) @(posedge clk);

    send_idle = 0;
    recv_idle = 0;
    set_count(17);
    send(CMD_INIT, 0, 0);
    random_burst(300);
    set_count(200);
    send(CMD_INIT, 0, 0);
    random_burst(200);

    while (pending != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
